FILE: rtl/core/srtp_pkg.sv
package srtp_pkg;

  localparam int NUM_PROCS = 16;
  localparam int SLOT_W    = $clog2(NUM_PROCS);
  localparam int CNT_W     = $clog2(NUM_PROCS + 1);
  localparam int TIME_W    = 24;
  localparam int BURST_W   = 16;
  localparam int TAG_W     = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [TAG_W-1:0]   proc_tag;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  run_tag;
    logic              idle;
    logic [TIME_W-1:0] tick_time;
    logic              first_run;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic              overflow;
  } rsp_t;

  // Running best candidate that travels down the row of cells.
  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [BURST_W-1:0] rem;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic               started;
  } wave_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               clear;
    logic               load;
    logic               commit;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_CALC,
    S_WB
  } state_t;

endpackage

FILE: rtl/core/srtp_cell.sv
module srtp_cell
  import srtp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] idx,
  input  logic              live,
  input  logic [TIME_W-1:0] now,
  input  cell_ctl_t         ctl,
  input  wave_t             wave_in,
  output wave_t             wave_out
);

  logic [TAG_W-1:0]   tag;
  logic [TIME_W-1:0]  arrival;
  logic [BURST_W-1:0] burst;
  logic [BURST_W-1:0] rem;
  logic               started;
  logic               done;
  logic               eligible;
  logic               hit;

  assign hit = (ctl.slot == idx);

  // Strict less-than keeps the earlier slot on a tie.
  assign eligible = live && !done && (arrival <= now) && (rem != '0) &&
                    (!wave_in.found || (rem < wave_in.rem));

  always_ff @(posedge clk) begin
    if (eligible) begin
      wave_out.found   <= 1'b1;
      wave_out.slot    <= idx;
      wave_out.rem     <= rem;
      wave_out.tag     <= tag;
      wave_out.arrival <= arrival;
      wave_out.burst   <= burst;
      wave_out.started <= started;
    end else begin
      wave_out <= wave_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && hit) begin
      tag     <= ctl.tag;
      arrival <= ctl.arrival;
      burst   <= ctl.burst;
      rem     <= ctl.burst;
    end else if (ctl.commit && hit) begin
      rem <= rem - BURST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      started <= 1'b0;
      done    <= 1'b0;
    end else if (ctl.load && hit) begin
      started <= 1'b0;
      done    <= 1'b0;
    end else if (ctl.commit && hit) begin
      started <= 1'b1;
      if (rem == BURST_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/srt_preemptive_scheduler.sv
// Shortest-remaining-time-first scheduler with a table of NUM_PROCS processes.
// Requests arrive on req (valid/ready) and each one produces exactly one
// result on rsp (valid/ready). A clear empties the table and resets time, a
// load appends one process, and a tick runs the process with the least
// remaining time among those that have arrived and are not finished.
// Each process sits in one cell of a row; on a tick the best candidate is
// handed from cell to cell, one cell per cycle, and the tick then passes
// through sweep, then turnaround, then writeback before its result.
// Clear, load and unused codes go straight to writeback. The row walk sets
// the tick latency; one request is in flight at a time.
// A new request is taken while an earlier result still waits on rsp; its own
// result, and the state update that goes with it, is held until rsp is free.
// Reset empties the table, clears all flags and counters and sets time to 0.
module srt_preemptive_scheduler
  import srtp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t             state;
  state_t             state_next;
  req_t               item;
  logic [SLOT_W-1:0]  sweep_cnt;
  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   loaded_count_next;
  logic [CNT_W-1:0]   completed_count;
  logic [CNT_W-1:0]   completed_count_next;
  logic [TIME_W-1:0]  current_time;
  logic [TIME_W-1:0]  current_time_next;
  logic [TIME_W-1:0]  next_time;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  burst_ext;
  logic               out_free;
  logic               wb_fire;
  logic [NUM_PROCS-1:0] live;
  cell_ctl_t          ctl;
  rsp_t               rsp_next;
  wave_t              wave [NUM_PROCS+1];
  wave_t              best;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign wb_fire   = (state == S_WB) && out_free;
  assign best      = wave[NUM_PROCS];
  assign wave[0]   = '0;
  assign next_time = (current_time == TIME_MAX) ? current_time
                                                : current_time + TIME_W'(1);
  assign burst_ext = {{(TIME_W-BURST_W){1'b0}}, best.burst};

  for (genvar g = 0; g < NUM_PROCS; g++) begin : g_cell
    assign live[g] = (CNT_W'(g) < loaded_count);

    srtp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (SLOT_W'(g)),
      .live     (live[g]),
      .now      (current_time),
      .ctl      (ctl),
      .wave_in  (wave[g]),
      .wave_out (wave[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (state == S_CALC) begin
      tat <= next_time - best.arrival;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (state == S_SWEEP) begin
      sweep_cnt <= sweep_cnt + SLOT_W'(1);
    end else begin
      sweep_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count    <= '0;
      completed_count <= '0;
      current_time    <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      loaded_count    <= loaded_count_next;
      completed_count <= completed_count_next;
      current_time    <= current_time_next;
      if (wb_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      rsp <= rsp_next;
    end
  end

  always_comb begin
    state_next           = state;
    loaded_count_next    = loaded_count;
    completed_count_next = completed_count;
    current_time_next    = current_time;
    rsp_next             = '0;
    ctl                  = '0;
    ctl.tag              = item.proc_tag;
    ctl.arrival          = item.arrival;
    ctl.burst            = (item.burst == '0) ? BURST_W'(1) : item.burst;
    ctl.slot             = loaded_count[SLOT_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.req_type == REQ_TICK) ? S_SWEEP : S_WB;
        end
      end
      S_SWEEP: begin
        if (sweep_cnt == SLOT_W'(NUM_PROCS - 1)) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          state_next = S_IDLE;
          if (item.req_type == REQ_CLEAR) begin
            ctl.clear            = 1'b1;
            loaded_count_next    = '0;
            completed_count_next = '0;
            current_time_next    = '0;
          end else if (item.req_type == REQ_LOAD) begin
            if (loaded_count >= CNT_W'(NUM_PROCS)) begin
              rsp_next.overflow = 1'b1;
            end else begin
              ctl.load          = 1'b1;
              loaded_count_next = loaded_count + CNT_W'(1);
            end
          end else if (item.req_type == REQ_TICK) begin
            rsp_next.tick_time = current_time;
            current_time_next  = next_time;
            if (!best.found) begin
              rsp_next.idle = 1'b1;
            end else begin
              ctl.commit         = 1'b1;
              ctl.slot           = best.slot;
              rsp_next.run_tag   = best.tag;
              rsp_next.first_run = !best.started;
              if (best.rem == BURST_W'(1)) begin
                rsp_next.finished    = 1'b1;
                rsp_next.turnaround  = tat;
                rsp_next.waiting     = (tat >= burst_ext) ? tat - burst_ext : '0;
                completed_count_next = completed_count + CNT_W'(1);
              end
            end
          end
          rsp_next.all_done = (completed_count_next == loaded_count_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srtp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 200;
  localparam int TICK_CAP = 150;

  typedef struct {
    logic [1:0]         rt;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  arr;
    logic [BURST_W-1:0] bur;
    bit                 typed;
    bit                 idle;
    bit                 all_done;
    bit                 ovf;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_word;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_word;

  // Scheduler state as the block should hold it.
  logic [TAG_W-1:0]   slot_tag [NUM_PROCS];
  logic [TIME_W-1:0]  slot_arrival [NUM_PROCS];
  logic [BURST_W-1:0] slot_burst [NUM_PROCS];
  logic [BURST_W-1:0] slot_left [NUM_PROCS];
  logic [NUM_PROCS-1:0] slot_started = '0;
  logic [NUM_PROCS-1:0] slot_done = '0;
  int n_loaded = 0;
  int n_completed = 0;
  logic [TIME_W-1:0] sched_now = '0;

  rsp_t sched_q [$];
  bit   pin_on;
  rsp_t pin_rsp;
  int   errors = 0;
  int   items_done = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   quiet_cycles = 0;

  int idle_by_phase [4] = '{0, 53, 0, 27};
  int stall_by_phase [4] = '{0, 0, 53, 27};

  plan_row_t plan [25] = '{
    '{REQ_TICK,   8'h00, 24'h000000, 16'h0000, 1, 1, 1, 0},
    '{REQ_UNUSED, 8'h00, 24'h000000, 16'h0000, 1, 0, 1, 0},
    '{REQ_CLEAR,  8'h00, 24'h000000, 16'h0000, 1, 0, 1, 0},
    '{REQ_LOAD,   8'hFF, 24'h000000, 16'h0000, 1, 0, 0, 0},
    '{REQ_LOAD,   8'h00, 24'hFFFFFF, 16'hFFFF, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h5A, 24'h000001, 16'h0002, 0, 0, 0, 0},
    '{REQ_LOAD,   8'hA5, 24'h000000, 16'h0001, 0, 0, 0, 0},
    '{REQ_TICK,   8'h00, 24'h000000, 16'h0000, 0, 0, 0, 0},
    '{REQ_TICK,   8'h00, 24'h000000, 16'h0000, 0, 0, 0, 0},
    '{REQ_TICK,   8'h00, 24'h000000, 16'h0000, 0, 0, 0, 0},
    '{REQ_TICK,   8'h00, 24'h000000, 16'h0000, 0, 0, 0, 0},
    '{REQ_TICK,   8'h00, 24'h000000, 16'h0000, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h11, 24'h000005, 16'h0003, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h22, 24'h000006, 16'h0001, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h33, 24'h000004, 16'h0006, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h44, 24'h000007, 16'h0002, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h55, 24'h000008, 16'h0004, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h66, 24'h000005, 16'h0002, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h77, 24'h00000A, 16'h0005, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h88, 24'h000009, 16'h0001, 0, 0, 0, 0},
    '{REQ_LOAD,   8'h99, 24'h000006, 16'h0003, 0, 0, 0, 0},
    '{REQ_LOAD,   8'hAA, 24'h000005, 16'h0002, 0, 0, 0, 0},
    '{REQ_LOAD,   8'hBB, 24'h000004, 16'h0001, 0, 0, 0, 0},
    '{REQ_LOAD,   8'hCC, 24'h000008, 16'h0006, 0, 0, 0, 0},
    '{REQ_LOAD,   8'hDE, 24'h000003, 16'h0002, 1, 0, 0, 1}
  };

  srt_preemptive_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_word)
  );

  always #2 clk = ~clk;

  function automatic req_t make_req(logic [1:0] rt, logic [TAG_W-1:0] tag,
                                    logic [TIME_W-1:0] arr, logic [BURST_W-1:0] bur);
    req_t r;
    r.req_type = rt;
    r.proc_tag = tag;
    r.arrival  = arr;
    r.burst    = bur;
    return r;
  endfunction

  // Applies one request to the scheduler state and returns its result.
  function automatic rsp_t sched_apply(req_t r);
    rsp_t o;
    int pick;
    logic [BURST_W-1:0] best;
    logic [TIME_W-1:0] nxt;
    logic [TIME_W-1:0] tat;
    logic [BURST_W-1:0] b;
    o = '0;
    pick = -1;
    best = '0;
    case (r.req_type)
      REQ_CLEAR: begin
        slot_started = '0;
        slot_done = '0;
        n_loaded = 0;
        n_completed = 0;
        sched_now = '0;
      end
      REQ_LOAD: begin
        if (n_loaded >= NUM_PROCS) begin
          o.overflow = 1'b1;
        end else begin
          b = (r.burst == '0) ? BURST_W'(1) : r.burst;
          slot_tag[n_loaded] = r.proc_tag;
          slot_arrival[n_loaded] = r.arrival;
          slot_burst[n_loaded] = b;
          slot_left[n_loaded] = b;
          slot_started[n_loaded] = 1'b0;
          slot_done[n_loaded] = 1'b0;
          n_loaded++;
        end
      end
      REQ_TICK: begin
        nxt = (sched_now == TIME_MAX) ? TIME_MAX : sched_now + TIME_W'(1);
        for (int i = 0; i < n_loaded; i++) begin
          if (!slot_done[i] && slot_arrival[i] <= sched_now && slot_left[i] != '0 &&
              (pick < 0 || slot_left[i] < best)) begin
            best = slot_left[i];
            pick = i;
          end
        end
        o.tick_time = sched_now;
        if (pick < 0) begin
          o.idle = 1'b1;
        end else begin
          o.run_tag = slot_tag[pick];
          if (!slot_started[pick]) begin
            slot_started[pick] = 1'b1;
            o.first_run = 1'b1;
          end
          slot_left[pick] = slot_left[pick] - BURST_W'(1);
          if (slot_left[pick] == '0) begin
            tat = nxt - slot_arrival[pick];
            slot_done[pick] = 1'b1;
            n_completed++;
            o.finished = 1'b1;
            o.turnaround = tat;
            o.waiting = (tat >= TIME_W'(slot_burst[pick])) ?
                        tat - TIME_W'(slot_burst[pick]) : '0;
          end
        end
        sched_now = nxt;
      end
      default: begin
      end
    endcase
    o.all_done = (n_completed == n_loaded);
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Requests are predicted as they are transferred; results are checked in order.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        want = sched_apply(req_word);
        if (pin_on) want = pin_rsp;
        sched_q = {sched_q, want};
      end
      if (rsp_valid && rsp_ready) begin
        if (sched_q.size() == 0) begin
          $error("result transfer with no result pending");
          errors++;
        end else begin
          want = sched_q.pop_front();
          check_field("run_tag", 32'(want.run_tag), 32'(rsp_word.run_tag));
          check_field("idle", 32'(want.idle), 32'(rsp_word.idle));
          check_field("tick_time", 32'(want.tick_time), 32'(rsp_word.tick_time));
          check_field("first_run", 32'(want.first_run), 32'(rsp_word.first_run));
          check_field("finished", 32'(want.finished), 32'(rsp_word.finished));
          check_field("turnaround", 32'(want.turnaround), 32'(rsp_word.turnaround));
          check_field("waiting", 32'(want.waiting), 32'(rsp_word.waiting));
          check_field("all_done", 32'(want.all_done), 32'(rsp_word.all_done));
          check_field("overflow", 32'(want.overflow), 32'(rsp_word.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("srt_preemptive_scheduler verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_req moves.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_word <= r;
    do @(posedge clk); while (!(req_valid && req_ready));
    if (r.req_type != REQ_UNUSED) items_done++;
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sched_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_load();
    logic [BURST_W-1:0] bur;
    bur = ($urandom_range(9) == 0) ? BURST_W'($urandom_range(9, 60))
                                   : BURST_W'($urandom_range(0, 6));
    send_req(make_req(REQ_LOAD, TAG_W'($urandom), sched_now + TIME_W'($urandom_range(0, 10)),
                      bur));
  endtask

  // One workload: mostly clear, load a batch, tick until done or TICK_CAP.
  task automatic run_workload();
    int nproc;
    int ticks;
    if ($urandom_range(99) < 6) begin
      send_req(make_req(2'($urandom_range(3)), TAG_W'($urandom), TIME_W'($urandom),
                        BURST_W'($urandom)));
      return;
    end
    if ($urandom_range(9) != 0) send_req(make_req(REQ_CLEAR, '0, '0, '0));
    nproc = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
    repeat (nproc) send_load();
    ticks = 0;
    while (n_completed != n_loaded && ticks < TICK_CAP) begin
      // A late arrival now and then forces a preemption check mid-run.
      if ($urandom_range(19) == 0) send_load();
      else send_req(make_req(REQ_TICK, '0, '0, '0));
      ticks++;
    end
    repeat ($urandom_range(0, 2)) send_req(make_req(REQ_TICK, '0, '0, '0));
  endtask

  initial begin
    int goal;
    rst = 1'b1;
    req_valid = 1'b0;
    req_word = '0;
    pin_on = 1'b0;
    pin_rsp = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      pin_on = plan[i].typed;
      pin_rsp = '0;
      pin_rsp.idle = plan[i].idle;
      pin_rsp.all_done = plan[i].all_done;
      pin_rsp.overflow = plan[i].ovf;
      send_req(make_req(plan[i].rt, plan[i].tag, plan[i].arr, plan[i].bur));
    end
    pin_on = 1'b0;
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      goal = items_done + PHASE_ITEMS;
      if (ph == 0 || ph == 3) hold_req++;
      while (items_done < goal) run_workload();
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("srt_preemptive_scheduler verification clean");
    end else begin
      $display("srt_preemptive_scheduler verification failed");
    end
    $finish;
  end

endmodule
